>>> hw/rtl/m2au_pkg.sv
// ----------------------------------------------------------------------------
// m2au_pkg
// Shared widths, limits and opcode codes of the 2x2 matrix arithmetic unit.
// ----------------------------------------------------------------------------
package m2au_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int FUNC_W        = 3;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FN_MATMUL = 3'd0,
    FN_MATVEC = 3'd1,
    FN_ADD    = 3'd2,
    FN_SUB    = 3'd3,
    FN_INV    = 3'd4,
    FN_DOT    = 3'd5
  } func_t;

endpackage

>>> hw/rtl/m2au_if.sv
// ----------------------------------------------------------------------------
// m2au_if
// Valid/ready channels of the matrix unit: operand transactions in, results out.
// ----------------------------------------------------------------------------
interface m2au_in_if import m2au_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [ELEM_W-1:0] first_e0;
  logic signed [ELEM_W-1:0] first_e1;
  logic signed [ELEM_W-1:0] first_e2;
  logic signed [ELEM_W-1:0] first_e3;
  logic signed [ELEM_W-1:0] second_e0;
  logic signed [ELEM_W-1:0] second_e1;
  logic signed [ELEM_W-1:0] second_e2;
  logic signed [ELEM_W-1:0] second_e3;

  modport source (output valid, func, first_e0, first_e1, first_e2, first_e3,
                  second_e0, second_e1, second_e2, second_e3, input ready);
  modport sink   (input valid, func, first_e0, first_e1, first_e2, first_e3,
                  second_e0, second_e1, second_e2, second_e3, output ready);
endinterface

interface m2au_out_if import m2au_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] result_e0;
  logic signed [ELEM_W-1:0] result_e1;
  logic signed [ELEM_W-1:0] result_e2;
  logic signed [ELEM_W-1:0] result_e3;
  logic                     singular;
  logic                     saturated;

  modport source (output valid, result_e0, result_e1, result_e2, result_e3,
                  singular, saturated, input ready);
  modport sink   (input valid, result_e0, result_e1, result_e2, result_e3,
                  singular, saturated, output ready);
endinterface

>>> hw/rtl/matrix2x2_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// matrix2x2_arithmetic_unit_core
// Pipelined 2x2 matrix unit in signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one transaction = opcode plus two 4-element operands.
//   out_if : one transaction per input = 4 result elements, singular and
//            saturated flags, in input order.
//   The pipeline has one multiply stage, one sum stage, one saturate/setup
//   stage, FRAC_BITS + 32 stages of the restoring divider used by the
//   inverse (one quotient bit per stage), and the output register. Every
//   opcode takes the same path.
//   Throughput is one transaction per cycle while out_if.ready is high.
//   Reset (rst_n low, synchronous) empties the pipeline; no output is valid
//   afterward until new transactions arrive.
//   When the receiver stalls, the whole pipeline holds and in_if.ready drops;
//   a waiting result stays stable on out_if until taken.
// ----------------------------------------------------------------------------
module matrix2x2_arithmetic_unit_core import m2au_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  m2au_in_if.sink    in_if,
  m2au_out_if.source out_if
);

  localparam int SSW = 65 - FRAC_BITS;
  localparam int DW  = 64 - FRAC_BITS;
  localparam int NW  = ELEM_W + FRAC_BITS;

  localparam logic signed [SSW-1:0] SMAX = SSW'(ELEM_MAX);
  localparam logic signed [SSW-1:0] SMIN = SSW'(ELEM_MIN);
  localparam logic [NW-1:0] QNEG_LIM = NW'(64'h8000_0000);
  localparam logic [NW-1:0] QPOS_LIM = NW'(64'h7fff_ffff);

  typedef struct packed {
    logic [3:0][ELEM_W-1:0] res;
    logic                   sat;
    logic                   sing;
    logic                   inv;
    logic [3:0]             neg;
    logic [DW-1:0]          d;
    logic [3:0][DW-1:0]     rem;
    logic [3:0][NW-1:0]     nq;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t        o;
    logic [DW:0] t;
    o = s;
    for (int i = 0; i < 4; i++) begin
      t = {s.rem[i], s.nq[i][NW-1]};
      if (t >= {1'b0, s.d}) begin
        t = t - {1'b0, s.d};
        o.nq[i] = {s.nq[i][NW-2:0], 1'b1};
      end else begin
        o.nq[i] = {s.nq[i][NW-2:0], 1'b0};
      end
      o.rem[i] = t[DW-1:0];
    end
    return o;
  endfunction

  logic en;

  // multiply stage
  logic signed [ELEM_W-1:0] a [4];
  logic signed [ELEM_W-1:0] b [4];
  logic signed [ELEM_W-1:0] ma [8];
  logic signed [ELEM_W-1:0] mb [8];
  logic                     va_r;
  logic [FUNC_W-1:0]        fa_r;
  logic signed [63:0]       p_r [8];
  logic signed [32:0]       as_r [4];
  logic signed [ELEM_W-1:0] aa_r [4];

  // sum stage
  logic                     vb_r;
  logic [FUNC_W-1:0]        fb_r;
  logic signed [SSW-1:0]    s_r [4];
  logic signed [32:0]       asb_r [4];
  logic signed [ELEM_W-1:0] ab_r [4];
  logic signed [64:0]       t_nxt [4];

  // setup stage and divider
  div_t dv_nxt;
  div_t dv_r [NW+1];
  logic dvld_r [NW+1];

  // output stage
  logic                     out_vld_r;
  logic [3:0][ELEM_W-1:0]   res_nxt;
  logic                     sat_nxt;
  logic [3:0][ELEM_W-1:0]   res_r;
  logic                     sat_r;
  logic                     sing_r;

  assign en          = !out_vld_r || out_if.ready;
  assign in_if.ready = en;

  assign a[0] = in_if.first_e0;
  assign a[1] = in_if.first_e1;
  assign a[2] = in_if.first_e2;
  assign a[3] = in_if.first_e3;
  assign b[0] = in_if.second_e0;
  assign b[1] = in_if.second_e1;
  assign b[2] = in_if.second_e2;
  assign b[3] = in_if.second_e3;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    unique case (in_if.func)
      FN_MATMUL: begin
        ma[0] = a[0]; mb[0] = b[0];
        ma[1] = a[1]; mb[1] = b[2];
        ma[2] = a[0]; mb[2] = b[1];
        ma[3] = a[1]; mb[3] = b[3];
        ma[4] = a[2]; mb[4] = b[0];
        ma[5] = a[3]; mb[5] = b[2];
        ma[6] = a[2]; mb[6] = b[1];
        ma[7] = a[3]; mb[7] = b[3];
      end
      FN_MATVEC: begin
        ma[0] = a[0]; mb[0] = b[0];
        ma[1] = a[1]; mb[1] = b[1];
        ma[2] = a[2]; mb[2] = b[0];
        ma[3] = a[3]; mb[3] = b[1];
      end
      FN_DOT: begin
        ma[0] = a[0]; mb[0] = b[0];
        ma[1] = a[1]; mb[1] = b[1];
      end
      FN_INV: begin
        ma[0] = a[0]; mb[0] = a[3];
        ma[1] = a[2]; mb[1] = a[1];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    t_nxt[0] = 65'(p_r[0]) + ((fa_r == FN_INV) ? -65'(p_r[1]) : 65'(p_r[1]));
    t_nxt[1] = 65'(p_r[2]) + 65'(p_r[3]);
    t_nxt[2] = 65'(p_r[4]) + 65'(p_r[5]);
    t_nxt[3] = 65'(p_r[6]) + 65'(p_r[7]);
  end

  always_comb begin
    logic signed [SSW-1:0]  v;
    logic signed [SSW-1:0]  det;
    logic [SSW-1:0]         dabs;
    logic [ELEM_W-1:0]      m;
    logic signed [ELEM_W-1:0] src [4];
    logic [3:0]             nneg;
    dv_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      if (fb_r == FN_MATMUL || fb_r == FN_MATVEC || fb_r == FN_DOT) begin
        v = s_r[i];
      end else if (fb_r == FN_ADD || fb_r == FN_SUB) begin
        v = SSW'(asb_r[i]);
      end else begin
        v = '0;
      end
      if (v > SMAX) begin
        dv_nxt.res[i] = ELEM_MAX;
        dv_nxt.sat    = 1'b1;
      end else if (v < SMIN) begin
        dv_nxt.res[i] = ELEM_MIN;
        dv_nxt.sat    = 1'b1;
      end else begin
        dv_nxt.res[i] = v[ELEM_W-1:0];
      end
    end
    det  = s_r[0];
    dabs = det[SSW-1] ? -det : det;
    dv_nxt.d    = dabs[DW-1:0];
    dv_nxt.sing = (fb_r == FN_INV) && (det == '0);
    dv_nxt.inv  = (fb_r == FN_INV) && (det != '0);
    src[0] = ab_r[3];
    src[1] = ab_r[1];
    src[2] = ab_r[2];
    src[3] = ab_r[0];
    nneg   = {ab_r[0][ELEM_W-1], (ab_r[2] > 0), (ab_r[1] > 0), ab_r[3][ELEM_W-1]};
    for (int i = 0; i < 4; i++) begin
      m = src[i][ELEM_W-1] ? -src[i] : src[i];
      dv_nxt.nq[i]  = {m, {FRAC_BITS{1'b0}}};
      dv_nxt.neg[i] = nneg[i] ^ det[SSW-1];
    end
  end

  always_comb begin
    div_t              f;
    logic [NW-1:0]     q;
    logic              any;
    logic [ELEM_W-1:0] qn;
    f   = dv_r[NW];
    any = 1'b0;
    for (int i = 0; i < 4; i++) begin
      q  = f.nq[i];
      qn = -q[ELEM_W-1:0];
      if (!f.inv) begin
        res_nxt[i] = f.res[i];
      end else if (f.neg[i]) begin
        if (q > QNEG_LIM) begin
          res_nxt[i] = ELEM_MIN;
          any        = 1'b1;
        end else begin
          res_nxt[i] = qn;
        end
      end else begin
        if (q > QPOS_LIM) begin
          res_nxt[i] = ELEM_MAX;
          any        = 1'b1;
        end else begin
          res_nxt[i] = q[ELEM_W-1:0];
        end
      end
    end
    sat_nxt = f.inv ? any : f.sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      out_vld_r <= 1'b0;
      for (int k = 0; k <= NW; k++) begin
        dvld_r[k] <= 1'b0;
      end
    end else if (en) begin
      va_r      <= in_if.valid;
      vb_r      <= va_r;
      dvld_r[0] <= vb_r;
      for (int k = 0; k < NW; k++) begin
        dvld_r[k+1] <= dvld_r[k];
      end
      out_vld_r <= dvld_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r <= in_if.func;
      for (int i = 0; i < 8; i++) begin
        p_r[i] <= 64'(ma[i]) * 64'(mb[i]);
      end
      for (int i = 0; i < 4; i++) begin
        as_r[i] <= (in_if.func == FN_SUB) ? 33'(a[i]) - 33'(b[i])
                                          : 33'(a[i]) + 33'(b[i]);
        aa_r[i] <= a[i];
      end
      fb_r <= fa_r;
      for (int i = 0; i < 4; i++) begin
        s_r[i]   <= t_nxt[i][64:FRAC_BITS];
        asb_r[i] <= as_r[i];
        ab_r[i]  <= aa_r[i];
      end
      dv_r[0] <= dv_nxt;
      for (int k = 0; k < NW; k++) begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
      res_r  <= res_nxt;
      sat_r  <= sat_nxt;
      sing_r <= dv_r[NW].sing;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.result_e0 = res_r[0];
  assign out_if.result_e1 = res_r[1];
  assign out_if.result_e2 = res_r[2];
  assign out_if.result_e3 = res_r[3];
  assign out_if.singular  = sing_r;
  assign out_if.saturated = sat_r;

endmodule

>>> hw/rtl/m2au_chk.sv
// ----------------------------------------------------------------------------
// m2au_chk
// Port-level checks of the matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module m2au_chk import m2au_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [ELEM_W-1:0] result_e0,
  input logic signed [ELEM_W-1:0] result_e1,
  input logic signed [ELEM_W-1:0] result_e2,
  input logic signed [ELEM_W-1:0] result_e3,
  input logic                     singular,
  input logic                     saturated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_e0) &&
    $stable(result_e1) && $stable(result_e2) && $stable(result_e3) &&
    $stable(singular) && $stable(saturated))
    else $error("stalled result changed");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && singular |-> !saturated && result_e0 == '0 &&
    result_e1 == '0 && result_e2 == '0 && result_e3 == '0)
    else $error("singular result not cleared");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind matrix2x2_arithmetic_unit_core m2au_chk u_m2au_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .result_e0 (out_if.result_e0),
  .result_e1 (out_if.result_e1),
  .result_e2 (out_if.result_e2),
  .result_e3 (out_if.result_e3),
  .singular  (out_if.singular),
  .saturated (out_if.saturated)
);
